### rtl/ttip_pkg.sv
// shared types, constants and the digit decoder for the text to integer parser
// used by the parse core, the top level and the port checker; no dependencies
`default_nettype none

package ttip_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int OFFSET_MAX   = 255;
   localparam int OFFSET_WIDTH = $clog2(OFFSET_MAX + 1);
   localparam int BASE_WIDTH   = 6;
   localparam int CHAR_WIDTH   = 8;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = BASE_WIDTH;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_SETTING = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE  = 1'd1;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;

   localparam logic [BASE_WIDTH-1:0] BASE_OCT = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX = 6'd16;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  start_req;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  value;
      logic [OFFSET_WIDTH-1:0] end_offset;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // 0-9, A-F, a-f
   function automatic digit_type digit_of(input logic [CHAR_WIDTH-1:0] c);
      digit_type d;
      d.ok  = 1'b1;
      d.val = 4'd0;
      priority if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.val = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d.val = 4'(c - CHAR_UPPER_A) + 4'd10;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d.val = 4'(c - CHAR_LOWER_A) + 4'd10;
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/ttip_core.sv
// parse state and per-character step: prefix handling, multiply-add, result
// depends on ttip_pkg
`default_nettype none

module ttip_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  step,
   input  wire ttip_pkg::req_type               item,
   input  wire [ttip_pkg::BASE_WIDTH-1:0]       base_setting,
   input  wire                                  signed_mode,
   output logic                                 emit,
   output ttip_pkg::rsp_type                    result
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_START, PH_FIRST, PH_ZERO, PH_XPEND, PH_DIGITS
   } phase_type;

   localparam int VW = ttip_pkg::VALUE_WIDTH;
   localparam int OW = ttip_pkg::OFFSET_WIDTH;
   localparam int BW = ttip_pkg::BASE_WIDTH;

   phase_type         phase_ff, phase_in;
   logic [BW-1:0]     base_ff, base_in;
   logic [VW-1:0]     acc_ff, acc_in;
   logic [OW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;

   // state as seen after a start restarts the string
   phase_type         st_phase;
   logic [BW-1:0]     st_base;
   logic [VW-1:0]     st_acc;
   logic [OW-1:0]     st_cnt;
   logic              st_neg;

   ttip_pkg::digit_type dig;
   logic              go_digit;
   logic              do_finish;
   logic [BW-1:0]     dbase;
   logic [OW-1:0]     dcnt;
   logic [VW+BW-1:0]  prod;

   function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] c);
      return (c == OW'(ttip_pkg::OFFSET_MAX)) ? c : c + OW'(1);
   endfunction

   always_comb begin
      st_phase = item.start_req ? PH_START : phase_ff;
      st_base  = item.start_req ? base_setting : base_ff;
      st_acc   = item.start_req ? '0 : acc_ff;
      st_cnt   = item.start_req ? '0 : cnt_ff;
      st_neg   = item.start_req ? 1'b0 : neg_ff;

      dig       = ttip_pkg::digit_of(item.character);
      phase_in  = st_phase;
      base_in   = st_base;
      acc_in    = st_acc;
      cnt_in    = st_cnt;
      neg_in    = st_neg;
      go_digit  = 1'b0;
      do_finish = 1'b0;
      dbase     = st_base;
      dcnt      = st_cnt;

      unique case (st_phase)
         PH_START, PH_FIRST: begin
            if (st_phase == PH_START && signed_mode &&
                item.character == ttip_pkg::CHAR_MINUS) begin
               neg_in   = 1'b1;
               cnt_in   = sat_inc(st_cnt);
               phase_in = PH_FIRST;
            end else if (item.character == ttip_pkg::CHAR_ZERO) begin
               cnt_in   = sat_inc(st_cnt);
               phase_in = PH_ZERO;
            end else begin
               go_digit = 1'b1;
               dbase    = (st_base == '0) ? ttip_pkg::BASE_DEC : st_base;
            end
         end
         PH_ZERO: begin
            if (item.character == ttip_pkg::CHAR_LOWER_X) begin
               phase_in = PH_XPEND;
            end else begin
               go_digit = 1'b1;
               dbase    = (st_base == '0) ? ttip_pkg::BASE_OCT : st_base;
            end
         end
         PH_XPEND: begin
            // the x only counts once a hex digit follows it
            if (dig.ok) begin
               go_digit = 1'b1;
               dbase    = ttip_pkg::BASE_HEX;
               dcnt     = sat_inc(st_cnt);
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_DIGITS: begin
            go_digit = 1'b1;
         end
         PH_IDLE: begin
         end
         default: begin
         end
      endcase

      prod = st_acc * dbase;

      if (go_digit) begin
         base_in = dbase;
         if (dig.ok && {{(BW-4){1'b0}}, dig.val} < dbase) begin
            acc_in   = prod[VW-1:0] + VW'(dig.val);
            cnt_in   = sat_inc(dcnt);
            phase_in = PH_DIGITS;
         end else begin
            do_finish = 1'b1;
         end
      end

      emit              = do_finish;
      result.value      = st_neg ? (VW'(0) - st_acc) : st_acc;
      result.end_offset = dcnt;
      if (do_finish) begin
         phase_in = PH_IDLE;
         cnt_in   = dcnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         base_ff  <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         neg_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         neg_ff   <= neg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/text_to_integer_parser.sv
// top level: input register, parse core, result register, configuration port
// depends on ttip_pkg and ttip_core
`default_nettype none

// Streaming text to integer parser. Send one character per transfer; mark the
// first character of each string with start_req. The base and signed mode
// registers are sampled when the start character is parsed. One result comes
// out at the first character that is not a digit of the base in use, giving
// the wrapped value and the count of consumed characters. The block takes one
// character every cycle unless the output stalls; a character waits in the
// input register and is parsed when the core steps, and its result, if any,
// goes to rsp_ on that same step. The cycle is set by the single multiply-add
// of the accumulator by the base in the parse step. When the result register
// is stalled the input side stalls too once its input register is full.
module text_to_integer_parser (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire ttip_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output ttip_pkg::rsp_type                          rsp_data,
   input  wire                                        csr_valid,
   output logic                                       csr_ready,
   input  wire [ttip_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire [ttip_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);

   ttip_pkg::req_type                     req_ff;
   logic                                  req_valid_ff, req_valid_in;
   ttip_pkg::rsp_type                     rsp_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [ttip_pkg::BASE_WIDTH-1:0]       base_setting_ff;
   logic                                  signed_mode_ff;

   logic                                  out_blocked;
   logic                                  step;
   logic                                  req_take;
   logic                                  emit;
   ttip_pkg::rsp_type                     result;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign step        = req_valid_ff && !out_blocked;
   assign req_stall   = req_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   ttip_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (req_ff),
      .base_setting (base_setting_ff),
      .signed_mode  (signed_mode_ff),
      .emit         (emit),
      .result       (result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         base_setting_ff <= '0;
         signed_mode_ff  <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ttip_pkg::CSR_BASE_SETTING: base_setting_ff <= csr_data;
               ttip_pkg::CSR_SIGNED_MODE:  signed_mode_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

### rtl/ttip_checker.sv
// port-level assertions for the text to integer parser, bound to the top level
// depends on ttip_pkg and text_to_integer_parser
`default_nettype none

module ttip_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_stall,
   input  wire                        rsp_valid,
   input  wire                        rsp_stall,
   input  wire ttip_pkg::rsp_type     rsp_data
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stall without a stalled result");

   // nothing consumed means nothing accumulated
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_offset == '0 |-> rsp_data.value == '0)
      else $error("nonzero value with zero offset");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### sim/text_to_integer_parser_test.sv
`timescale 1ns / 100ps
// testbench for text_to_integer_parser: a table of directed strings, then random strings
// under several base/sign settings, results checked against typed rows or an in-bench parse model
// depends on ttip_pkg and the text_to_integer_parser rtl

module text_to_integer_parser_test;

   localparam int NO_TERM  = -1;
   localparam int DIR_ROWS = 11;
   localparam int BW       = ttip_pkg::BASE_WIDTH;
   localparam int VW       = ttip_pkg::VALUE_WIDTH;
   localparam int OW       = ttip_pkg::OFFSET_WIDTH;
   localparam int CW       = ttip_pkg::CHAR_WIDTH;

   typedef enum logic [2:0] {
      PS_IDLE, PS_START, PS_FIRST, PS_ZERO, PS_XPEND, PS_DIGITS
   } parse_phase_type;

   typedef struct packed {
      logic [BW-1:0]           base;
      logic                    sgn;
      logic                    lead_start;
      logic [47:0]             text;
      int                      term;
      logic                    typed;
      logic [VW-1:0]           value;
      logic [OW-1:0]           offset;
   } dir_row_type;

   logic                                  clock;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   ttip_pkg::req_type                     req_data = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   ttip_pkg::rsp_type                     rsp_data;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [ttip_pkg::CSR_INDEX_WIDTH-1:0]  csr_index = ttip_pkg::CSR_BASE_SETTING;
   logic [ttip_pkg::CSR_DATA_WIDTH-1:0]   csr_data = '0;

   // typed directed rows carry their own expectation alongside the character
   logic                         dir_typed = 1'b0;
   ttip_pkg::rsp_type            dir_want = '0;

   // parse model state and its copy of the registers
   parse_phase_type              ps_phase = PS_IDLE;
   logic [BW-1:0]                ps_base = '0;
   logic [VW-1:0]                ps_acc = '0;
   logic [OW-1:0]                ps_count = '0;
   logic                         ps_neg = 1'b0;
   logic [BW-1:0]                cfg_base = '0;
   logic                         cfg_signed = 1'b0;

   ttip_pkg::rsp_type            pending_numbers[$];
   dir_row_type                  dir_rows [0:DIR_ROWS-1];
   int                           dir_count = 0;

   int                           send_idle_pct = 15;
   int                           recv_idle_pct = 64;
   int                           sent_count = 0;
   int                           chars_seen = 0;
   int                           numbers_checked = 0;
   int                           settings_used = 0;
   int                           mismatches = 0;

   text_to_integer_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d numbers still pending", pending_numbers.size());
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------- parse model

   function automatic int hex_value(input logic [CW-1:0] c);
      if (c >= ttip_pkg::CHAR_ZERO && c <= ttip_pkg::CHAR_NINE)
         return int'(c - ttip_pkg::CHAR_ZERO);
      if (c >= ttip_pkg::CHAR_UPPER_A && c <= ttip_pkg::CHAR_UPPER_F)
         return int'(c - ttip_pkg::CHAR_UPPER_A) + 10;
      if (c >= ttip_pkg::CHAR_LOWER_A && c <= ttip_pkg::CHAR_LOWER_F)
         return int'(c - ttip_pkg::CHAR_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic void count_char();
      if (ps_count != OW'(ttip_pkg::OFFSET_MAX)) ps_count = ps_count + 1'b1;
   endfunction

   function automatic bit close_number(output ttip_pkg::rsp_type res);
      res.value      = ps_neg ? -ps_acc : ps_acc;
      res.end_offset = ps_count;
      ps_phase       = PS_IDLE;
      return 1'b1;
   endfunction

   function automatic bit take_digit(input logic [CW-1:0] c,
                                     output ttip_pkg::rsp_type res);
      int d;
      d = hex_value(c);
      res = '0;
      if (d < 0 || d >= int'(ps_base)) return close_number(res);
      ps_acc = ps_acc * ps_base + VW'(d);
      count_char();
      ps_phase = PS_DIGITS;
      return 1'b0;
   endfunction

   function automatic bit parse_char(input logic [CW-1:0] c, input logic start,
                                     output ttip_pkg::rsp_type res);
      bit done;
      done = 1'b0;
      res  = '0;
      if (start) begin
         ps_phase = PS_START;
         ps_base  = cfg_base;
         ps_acc   = '0;
         ps_count = '0;
         ps_neg   = 1'b0;
      end
      case (ps_phase)
         PS_START, PS_FIRST: begin
            if (ps_phase == PS_START && cfg_signed && c == ttip_pkg::CHAR_MINUS) begin
               ps_neg = 1'b1;
               count_char();
               ps_phase = PS_FIRST;
            end else if (c == ttip_pkg::CHAR_ZERO) begin
               count_char();
               ps_phase = PS_ZERO;
            end else begin
               if (ps_base == 0) ps_base = ttip_pkg::BASE_DEC;
               done = take_digit(c, res);
            end
         end
         PS_ZERO: begin
            if (c == ttip_pkg::CHAR_LOWER_X) begin
               ps_phase = PS_XPEND;
            end else begin
               if (ps_base == 0) ps_base = ttip_pkg::BASE_OCT;
               done = take_digit(c, res);
            end
         end
         // hex only if the byte after the x is a hex digit
         PS_XPEND: begin
            if (hex_value(c) >= 0) begin
               ps_base = ttip_pkg::BASE_HEX;
               count_char();
               done = take_digit(c, res);
            end else begin
               done = close_number(res);
            end
         end
         PS_DIGITS: done = take_digit(c, res);
         default: ;
      endcase
      return done;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string what, input ttip_pkg::rsp_type want,
                                input ttip_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d: %s, expected value %h offset %0d, got value %h offset %0d",
                  mismatches, what, want.value, want.end_offset, got.value, got.end_offset);
   endtask

   always @(posedge clock) begin
      ttip_pkg::rsp_type predicted;
      ttip_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_numbers.size() == 0) begin
               note_mismatch("result with nothing pending", '0, rsp_data);
            end else begin
               want = pending_numbers.pop_front();
               if (rsp_data.value !== want.value || rsp_data.end_offset !== want.end_offset)
                  note_mismatch("wrong result", want, rsp_data);
               numbers_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ttip_pkg::CSR_BASE_SETTING: cfg_base = csr_data;
               ttip_pkg::CSR_SIGNED_MODE:  cfg_signed = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            chars_seen++;
            if (parse_char(req_data.character, req_data.start_req, predicted))
               pending_numbers.push_back(dir_typed ? dir_want : predicted);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------- driving

   task automatic send_char(input logic [CW-1:0] c, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {c, start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // let every pending result come out, then let bytes that give no result pass through too
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [BW-1:0] b, input logic sgn);
      csr_valid <= 1'b1;
      csr_index <= ttip_pkg::CSR_BASE_SETTING;
      csr_data  <= b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= ttip_pkg::CSR_SIGNED_MODE;
      csr_data  <= ttip_pkg::CSR_DATA_WIDTH'(sgn);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic add_row(input logic [BW-1:0] b, input logic sgn, input logic lead,
                          input logic [47:0] txt, input int term, input logic typed,
                          input logic [VW-1:0] v, input logic [OW-1:0] off);
      dir_rows[dir_count].base       = b;
      dir_rows[dir_count].sgn        = sgn;
      dir_rows[dir_count].lead_start = lead;
      dir_rows[dir_count].text       = txt;
      dir_rows[dir_count].term       = term;
      dir_rows[dir_count].typed      = typed;
      dir_rows[dir_count].value      = v;
      dir_rows[dir_count].offset     = off;
      dir_count++;
   endtask

   // optional minus, optional 0 or 0x prefix, digits of the base in use, optional terminator
   task automatic send_random_string(input logic [BW-1:0] base, input logic sgn,
                                     input int ndigits, input bit clean);
      int eb;
      int v;
      int form;
      int term;
      bit first;
      logic [CW-1:0] c;
      first = 1'b1;
      eb = (base == 0) ? 10 : int'(base);
      if ((sgn && $urandom_range(1) == 1) || $urandom_range(5) == 0) begin
         send_char(ttip_pkg::CHAR_MINUS, first);
         first = 1'b0;
      end
      form = $urandom_range(9);
      if (form <= 3) begin
         send_char(ttip_pkg::CHAR_ZERO, first);
         send_char(ttip_pkg::CHAR_LOWER_X, 1'b0);
         first = 1'b0;
         eb = 16;
         // bare 0x, the lookahead sees the terminator
         if (form == 3 && !clean) ndigits = 0;
      end else if (form <= 5) begin
         send_char(ttip_pkg::CHAR_ZERO, first);
         first = 1'b0;
         eb = (base == 0) ? 8 : int'(base);
      end
      if (eb > 16) eb = 16;
      for (int k = 0; k < ndigits; k++) begin
         v = $urandom_range(eb - 1);
         if (v < 10) c = ttip_pkg::CHAR_ZERO + CW'(v);
         else if ($urandom_range(1) == 1) c = ttip_pkg::CHAR_UPPER_A + CW'(v - 10);
         else c = ttip_pkg::CHAR_LOWER_A + CW'(v - 10);
         if (!clean && $urandom_range(39) == 0) c = CW'($urandom_range(255));
         send_char(c, first || (!clean && $urandom_range(49) == 0));
         first = 1'b0;
      end
      term = $urandom_range(9);
      // term 0 leaves the string unfinished for the next start to drop
      if (term != 0 || clean) begin
         if (term <= 2) c = 8'h00;
         else if (term == 3) c = 8'h20;
         else c = CW'($urandom_range(255));
         send_char(c, first);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [CW-1:0] c;
      logic [BW-1:0] b;
      logic sgn;
      bit first;
      int budget;

      //      base   sgn   start text   terminator  typed value          offset
      add_row(6'd0,  1'b0, 1'b0, "5",   NO_TERM,    1'b0, 32'd0,         8'd0); // before any start
      add_row(6'd0,  1'b0, 1'b1, "7",   8'h00,      1'b1, 32'd7,         8'd1);
      add_row(6'd0,  1'b0, 1'b1, "-5",  NO_TERM,    1'b1, 32'd0,         8'd0); // minus not allowed
      add_row(6'd0,  1'b0, 1'b1, "0x",  "z",        1'b1, 32'd0,         8'd1); // no hex after x
      add_row(6'd0,  1'b0, 1'b1, "07",  "8",        1'b1, 32'd7,         8'd2); // octal
      add_row(6'd10, 1'b0, 1'b1, "12",  NO_TERM,    1'b0, 32'd0,         8'd0); // left unfinished
      add_row(6'd10, 1'b0, 1'b1, "0xA", 8'h00,      1'b1, 32'd10,        8'd3); // hex over base 10
      add_row(6'd0,  1'b1, 1'b1, "-1",  8'h00,      1'b1, 32'hFFFF_FFFF, 8'd2);
      add_row(6'd0,  1'b1, 1'b1, "-",   " ",        1'b1, 32'd0,         8'd1); // minus alone
      add_row(6'd1,  1'b0, 1'b1, "00",  "1",        1'b1, 32'd0,         8'd2); // base one
      add_row(6'd36, 1'b1, 1'b1, "fF",  8'hFF,      1'b0, 32'd0,         8'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_count; i++) begin
         if (i == 0 || dir_rows[i].base != dir_rows[i-1].base ||
             dir_rows[i].sgn != dir_rows[i-1].sgn) begin
            drain();
            set_config(dir_rows[i].base, dir_rows[i].sgn);
         end
         dir_typed <= dir_rows[i].typed;
         dir_want  <= {dir_rows[i].value, dir_rows[i].offset};
         first = 1'b1;
         for (int k = 5; k >= 0; k--) begin
            c = dir_rows[i].text[8*k +: 8];
            if (c != 8'h00) begin
               send_char(c, first && dir_rows[i].lead_start);
               first = 1'b0;
            end
         end
         if (dir_rows[i].term != NO_TERM) send_char(CW'(dir_rows[i].term), 1'b0);
      end
      dir_typed <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
         recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 15 : 0;
         for (int s = 0; s < 6; s++) begin
            case (s)
               0: b = 6'd0;
               1: b = 6'd36;
               2: b = 6'd1;
               3: b = BW'($urandom_range(2, 36));
               4: b = BW'($urandom_range(37, 63));
               default: b = BW'($urandom_range(36));
            endcase
            sgn = 1'((s + ph) % 2);
            drain();
            set_config(b, sgn);
            // one string long enough to saturate the offset
            if (ph == 0 && s == 5) send_random_string(b, sgn, 260, 1'b1);
            budget = sent_count + 75;
            while (sent_count < budget) begin
               if ($urandom_range(9) == 0)
                  repeat ($urandom_range(1, 3)) send_char(CW'($urandom_range(255)), 1'b0);
               send_random_string(b, sgn, ($urandom_range(7) == 0) ? $urandom_range(7, 12)
                                                                 : $urandom_range(0, 6), 1'b0);
            end
         end
      end

      drain();
      $display("sent %0d characters under %0d register settings, %0d parsed numbers checked",
               chars_seen, settings_used, numbers_checked);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### text_to_integer_parser.f
rtl/ttip_pkg.sv
rtl/ttip_core.sv
rtl/text_to_integer_parser.sv
rtl/ttip_checker.sv
sim/text_to_integer_parser_test.sv
